// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled while reset is asserted.
`define CMP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Same-cycle implication check.
`define CMP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check.
`define CMP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cmpcal_pkg.sv =====
`default_nettype none

package cmpcal_pkg;

  // Default sizes
  localparam int unsigned SAMPLE_BITS_DEF = 13;
  localparam int unsigned CORDIC_ITER_DEF = 16;

  // Fixed field widths
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned DECL_W     = 13;
  localparam int unsigned LIMIT_W    = 12;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned HEAD_W     = 9;

  // Angle accumulator: 1/4096 degree, signed
  localparam int unsigned ANG_W      = 23;
  localparam int unsigned FRAC_W     = 12;
  localparam int unsigned DECL_SHIFT = 8;
  localparam int unsigned ATAN_LEN   = 24;
  localparam int unsigned ATAN_IDX_W = 5;
  localparam logic signed [ANG_W-1:0] HALF_TURN = 23'sd737280;
  localparam logic signed [ANG_W-1:0] FULL_TURN = 23'sd1474560;

  // Whole-degree heading before wrap
  localparam int unsigned HW = 12;
  localparam logic signed [HW-1:0] DEG_180 = 12'sd180;
  localparam logic signed [HW-1:0] DEG_360 = 12'sd360;
  localparam logic signed [HW-1:0] DEG_720 = 12'sd720;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd1000;

  typedef enum logic [REQ_W-1:0] {
    REQ_HEADING = 2'd0,
    REQ_CALIB   = 2'd1,
    REQ_COMMIT  = 2'd2,
    REQ_LOAD    = 2'd3
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECLINATION  = 1'b0,
    CFG_REJECT_LIMIT = 1'b1
  } cfg_idx_e;

  // Controller to datapath
  typedef struct packed {
    logic                  capture;
    logic                  rot;
    logic [ATAN_IDX_W-1:0] iter;
    logic                  ang;
    logic                  finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_heading;
  } status_t;

  // atan(2^-i) in degrees times 4096, rounded
  function automatic logic [ANG_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANG_W-1:0] v;
    unique case (idx)
      5'd0:    v = 23'd184320;
      5'd1:    v = 23'd108810;
      5'd2:    v = 23'd57492;
      5'd3:    v = 23'd29184;
      5'd4:    v = 23'd14649;
      5'd5:    v = 23'd7331;
      5'd6:    v = 23'd3667;
      5'd7:    v = 23'd1833;
      5'd8:    v = 23'd917;
      5'd9:    v = 23'd458;
      5'd10:   v = 23'd229;
      5'd11:   v = 23'd115;
      5'd12:   v = 23'd57;
      5'd13:   v = 23'd29;
      5'd14:   v = 23'd14;
      5'd15:   v = 23'd7;
      5'd16:   v = 23'd4;
      5'd17:   v = 23'd2;
      5'd18:   v = 23'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== design/cmpcal_if.sv =====
`default_nettype none

// Request channel: request type and three axis values
interface cmpcal_req_if #(
  parameter int unsigned SampleBits = cmpcal_pkg::SAMPLE_BITS_DEF
);
  import cmpcal_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [REQ_W-1:0]             req_type;
  logic signed [SampleBits-1:0] x_value;
  logic signed [SampleBits-1:0] y_value;
  logic signed [SampleBits-1:0] z_value;

  modport source (output valid, req_type, x_value, y_value, z_value, input ready);
  modport sink   (input valid, req_type, x_value, y_value, z_value, output ready);
endinterface

// Result channel: heading, flags and current offsets
interface cmpcal_rsp_if #(
  parameter int unsigned SampleBits = cmpcal_pkg::SAMPLE_BITS_DEF
);
  import cmpcal_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [HEAD_W-1:0]            heading_deg;
  logic                         heading_valid;
  logic                         sample_rejected;
  logic signed [SampleBits-1:0] offset_x;
  logic signed [SampleBits-1:0] offset_y;
  logic signed [SampleBits-1:0] offset_z;

  modport source (output valid, heading_deg, heading_valid, sample_rejected,
                  offset_x, offset_y, offset_z, input ready);
  modport sink   (input valid, heading_deg, heading_valid, sample_rejected,
                  offset_x, offset_y, offset_z, output ready);
endinterface

`default_nettype wire

// ===== design/cmpcal_ctrl.sv =====
`default_nettype none

module cmpcal_ctrl #(
  parameter int unsigned CordicIterations = cmpcal_pkg::CORDIC_ITER_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire cmpcal_pkg::status_t status_i,
  output cmpcal_pkg::cmd_t         cmd_o
);
  import cmpcal_pkg::*;

  localparam int unsigned NumIter = (CordicIterations < ATAN_LEN) ? CordicIterations
                                                                   : ATAN_LEN;
  localparam int unsigned IterW   = $clog2(NumIter);
  localparam logic [IterW-1:0] IterLast = IterW'(NumIter - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ROT  = 4'b0010,
    ST_ANG  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [IterW-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept, finish;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  // result register must be free or draining this cycle
  assign finish      = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d   = '0;
          state_d = status_i.in_heading ? ST_ROT : ST_DONE;
        end
      end
      ST_ROT: begin
        if (cnt_q == IterLast) begin
          state_d = ST_ANG;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_ANG: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // commands
  always_comb begin
    cmd_o.capture = accept;
    cmd_o.rot     = (state_q == ST_ROT);
    cmd_o.iter    = ATAN_IDX_W'(cnt_q);
    cmd_o.ang     = (state_q == ST_ANG);
    cmd_o.finish  = finish;
  end

endmodule

`default_nettype wire

// ===== design/cmpcal_dp.sv =====
`default_nettype none

module cmpcal_dp #(
  parameter int unsigned SampleBits = cmpcal_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [cmpcal_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [cmpcal_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  wire logic [cmpcal_pkg::REQ_W-1:0]         req_type_i,
  input  wire logic signed [SampleBits-1:0]         x_value_i,
  input  wire logic signed [SampleBits-1:0]         y_value_i,
  input  wire logic signed [SampleBits-1:0]         z_value_i,
  input  wire cmpcal_pkg::cmd_t                     cmd_i,
  output cmpcal_pkg::status_t                       status_o,
  output logic [cmpcal_pkg::HEAD_W-1:0]             heading_deg_o,
  output logic                                      heading_valid_o,
  output logic                                      sample_rejected_o,
  output logic signed [SampleBits-1:0]              offset_x_o,
  output logic signed [SampleBits-1:0]              offset_y_o,
  output logic signed [SampleBits-1:0]              offset_z_o
);
  import cmpcal_pkg::*;

  localparam int unsigned SB   = SampleBits;
  localparam int unsigned XW   = SB + 3;               // CORDIC vector incl. gain
  localparam int unsigned MW   = (SB + 1 > LIMIT_W) ? SB + 1 : LIMIT_W;
  localparam int unsigned QW   = ANG_W - FRAC_W;

  // configuration
  logic signed [DECL_W-1:0] decl_q;
  logic [LIMIT_W-1:0]       limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decl_q  <= '0;
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DECLINATION:  decl_q  <= cfg_wdata_i[DECL_W-1:0];
        CFG_REJECT_LIMIT: limit_q <= cfg_wdata_i[LIMIT_W-1:0];
      endcase
    end
  end

  assign status_o.in_heading = (req_type_e'(req_type_i) == REQ_HEADING);

  // calibration and offset state
  logic signed [SB-1:0] max_q [3];
  logic signed [SB-1:0] min_q [3];
  logic signed [SB-1:0] off_q [3];
  logic signed [SB-1:0] max_d [3];
  logic signed [SB-1:0] min_d [3];
  logic signed [SB-1:0] off_d [3];

  // captured request
  req_type_e            req_q;
  logic signed [SB-1:0] s_q [3];

  // CORDIC working registers
  logic signed [XW-1:0]    x_q, y_q;
  logic signed [ANG_W-1:0] z_q, a_q;

  // heading capture: remove offset, fold left half-plane by 180 degrees
  logic signed [SB:0]   cx, cy;
  logic signed [XW-1:0] cx_ext, cy_ext;

  assign cx     = {x_value_i[SB-1], x_value_i} - {off_q[0][SB-1], off_q[0]};
  assign cy     = {y_value_i[SB-1], y_value_i} - {off_q[1][SB-1], off_q[1]};
  assign cx_ext = {{2{cx[SB]}}, cx};
  assign cy_ext = {{2{cy[SB]}}, cy};

  // one CORDIC micro-rotation
  logic signed [XW-1:0]    xs, ys;
  logic signed [ANG_W-1:0] at;

  assign xs = x_q >>> cmd_i.iter;
  assign ys = y_q >>> cmd_i.iter;
  assign at = signed'(atan_entry(cmd_i.iter));

  // angle wrap and declination
  logic signed [ANG_W-1:0] zw, decl_ang;

  always_comb begin
    priority if (z_q < 0) begin
      zw = z_q + FULL_TURN;
    end else if (z_q >= FULL_TURN) begin
      zw = z_q - FULL_TURN;
    end else begin
      zw = z_q;
    end
  end

  assign decl_ang = {{(ANG_W - DECL_W - DECL_SHIFT){decl_q[DECL_W-1]}}, decl_q,
                     {DECL_SHIFT{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_e'(req_type_i);
      s_q[0] <= x_value_i;
      s_q[1] <= y_value_i;
      s_q[2] <= z_value_i;
      if (cx[SB]) begin
        x_q <= -cx_ext;
        y_q <= -cy_ext;
        z_q <= HALF_TURN;
      end else begin
        x_q <= cx_ext;
        y_q <= cy_ext;
        z_q <= '0;
      end
    end else if (cmd_i.rot) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end else if (y_q < 0) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end
    end
    if (cmd_i.ang) begin
      a_q <= zw - decl_ang;
    end
  end

  // whole degrees, truncated toward zero, plus 180, wrapped into 0..359
  logic signed [QW-1:0] q_floor;
  logic                 q_fix;
  logic signed [HW-1:0] h_raw, h_wrap;

  assign q_floor = a_q[ANG_W-1:FRAC_W];
  assign q_fix   = a_q[ANG_W-1] && (a_q[FRAC_W-1:0] != '0);
  assign h_raw   = {{(HW - QW){q_floor[QW-1]}}, q_floor} + HW'(q_fix) + DEG_180;

  always_comb begin
    priority if (h_raw < 0) begin
      h_wrap = h_raw + DEG_360;
    end else if (h_raw >= DEG_720) begin
      h_wrap = h_raw - DEG_720;
    end else if (h_raw >= DEG_360) begin
      h_wrap = h_raw - DEG_360;
    end else begin
      h_wrap = h_raw;
    end
  end

  // calibration reject test
  logic [MW-1:0]      mag [3];
  logic               drop;
  logic signed [SB:0] sum [3];
  logic signed [SB:0] half [3];

  always_comb begin
    drop = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (s_q[k][SB-1]) begin
        mag[k] = MW'(-{s_q[k][SB-1], s_q[k]});
      end else begin
        mag[k] = MW'({1'b0, s_q[k]});
      end
      if (mag[k] > MW'(limit_q)) begin
        drop = 1'b1;
      end
      // midpoint, truncated toward zero
      sum[k]  = {max_q[k][SB-1], max_q[k]} + {min_q[k][SB-1], min_q[k]};
      half[k] = (sum[k] + (SB + 1)'(sum[k][SB])) >>> 1;
    end
  end

  // state update for the finishing request
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      max_d[k] = max_q[k];
      min_d[k] = min_q[k];
      off_d[k] = off_q[k];
    end
    unique case (req_q)
      REQ_HEADING: begin
      end
      REQ_CALIB: begin
        if (!drop) begin
          for (int k = 0; k < 3; k++) begin
            if (s_q[k] > max_q[k]) max_d[k] = s_q[k];
            if (s_q[k] < min_q[k]) min_d[k] = s_q[k];
          end
        end
      end
      REQ_COMMIT: begin
        for (int k = 0; k < 3; k++) begin
          off_d[k] = half[k][SB-1:0];
          max_d[k] = '0;
          min_d[k] = '0;
        end
      end
      REQ_LOAD: begin
        for (int k = 0; k < 3; k++) begin
          off_d[k] = s_q[k];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        max_q[k] <= '0;
        min_q[k] <= '0;
        off_q[k] <= '0;
      end
    end else if (cmd_i.finish) begin
      for (int k = 0; k < 3; k++) begin
        max_q[k] <= max_d[k];
        min_q[k] <= min_d[k];
        off_q[k] <= off_d[k];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      heading_deg_o     <= (req_q == REQ_HEADING) ? h_wrap[HEAD_W-1:0] : '0;
      heading_valid_o   <= (req_q == REQ_HEADING);
      sample_rejected_o <= (req_q == REQ_CALIB) && drop;
      offset_x_o        <= off_d[0];
      offset_y_o        <= off_d[1];
      offset_z_o        <= off_d[2];
    end
  end

endmodule

`default_nettype wire

// ===== design/compass_hard_iron_calibration_heading.sv =====
`default_nettype none

// Hard-iron calibrated compass heading. Each request on req_i yields one
// result on rsp_o. A heading request subtracts the stored offsets from x and
// y, finds the vector angle with an iterative CORDIC, removes the declination
// (1/16 degree) and returns the heading in whole degrees 0..359. Calibration
// requests track per-axis max/min (dropped if any axis magnitude exceeds the
// reject limit), commit sets offsets to the midpoints and clears the
// trackers, load writes the offsets directly. The block takes one request at
// a time: a heading request runs min(CordicIterations, 24) micro-rotations
// on the single shift-add CORDIC unit, one micro-rotation per cycle, then
// applies angle wrap and declination into a register and does the degree
// conversion on the way into the output register; other requests go from
// acceptance straight to the final step that writes the output register. A
// new request is accepted as soon as the previous result sits in the output
// register. A stalled result holds the block in its final step and blocks
// the input.
// The user makes configuration writes (declination, reject limit) through
// cfg_we_i only while the block is idle; the block does not enforce this.
module compass_hard_iron_calibration_heading #(
  parameter int unsigned SampleBits       = cmpcal_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned CordicIterations = cmpcal_pkg::CORDIC_ITER_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [cmpcal_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [cmpcal_pkg::CFG_W-1:0]     cfg_wdata_i,
  cmpcal_req_if.sink                            req_i,
  cmpcal_rsp_if.source                          rsp_o
);
  import cmpcal_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;
  logic    out_valid;

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid;

  cmpcal_ctrl #(
    .CordicIterations(CordicIterations)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cmpcal_dp #(
    .SampleBits(SampleBits)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .req_type_i        (req_i.req_type),
    .x_value_i         (req_i.x_value),
    .y_value_i         (req_i.y_value),
    .z_value_i         (req_i.z_value),
    .cmd_i             (cmd),
    .status_o          (status),
    .heading_deg_o     (rsp_o.heading_deg),
    .heading_valid_o   (rsp_o.heading_valid),
    .sample_rejected_o (rsp_o.sample_rejected),
    .offset_x_o        (rsp_o.offset_x),
    .offset_y_o        (rsp_o.offset_y),
    .offset_z_o        (rsp_o.offset_z)
  );

endmodule

`default_nettype wire

// ===== design/cmpcal_chk.sv =====
`default_nettype none

`include "assert_macros.svh"

module cmpcal_chk (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [cmpcal_pkg::HEAD_W-1:0] heading_deg_i,
  input wire logic                          heading_valid_i,
  input wire logic                          sample_rejected_i
);
  import cmpcal_pkg::*;

  // heading always wrapped into a full circle
  `CMP_ASSERT_IMPL(a_heading_range, clk_i, rst_ni, out_valid_i && heading_valid_i, heading_deg_i <= 9'd359, "heading out of range")

  // non-heading results carry a zero heading
  `CMP_ASSERT_IMPL(a_heading_zero, clk_i, rst_ni, out_valid_i && !heading_valid_i, heading_deg_i == '0, "heading set on non-heading result")

  // a result is never both a heading and a calibration reject
  `CMP_ASSERT(a_flags_excl, clk_i, rst_ni, !(out_valid_i && heading_valid_i && sample_rejected_i), "heading and reject both set")

  // one request in flight: ready drops after each acceptance
  `CMP_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "request accepted back to back")

  // stalled result holds
  `CMP_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(heading_deg_i), "stalled result changed")

endmodule

bind compass_hard_iron_calibration_heading cmpcal_chk u_cmpcal_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (req_i.valid),
  .in_ready_i        (req_i.ready),
  .out_valid_i       (rsp_o.valid),
  .out_ready_i       (rsp_o.ready),
  .heading_deg_i     (rsp_o.heading_deg),
  .heading_valid_i   (rsp_o.heading_valid),
  .sample_rejected_i (rsp_o.sample_rejected)
);

`default_nettype wire

// ===== sim/compass_hard_iron_calibration_heading_test.sv =====
`timescale 1ns / 100ps

module compass_hard_iron_calibration_heading_test;
  import cmpcal_pkg::*;

  localparam int SW          = SAMPLE_BITS_DEF;
  localparam int ROT_STEPS   = CORDIC_ITER_DEF;
  localparam int Q12_DEG     = 4096;
  localparam int STALL_LIMIT = 2000;
  localparam int CHUNK_LEN   = 42;
  localparam int PICK_RANDOM = 9999;

  typedef logic signed [SW-1:0] sample_t;

  typedef struct packed {
    req_type_e kind;
    sample_t   x;
    sample_t   y;
    sample_t   z;
  } mag_req_t;

  typedef struct packed {
    logic [HEAD_W-1:0] heading;
    logic              hvalid;
    logic              rejected;
    sample_t           ox;
    sample_t           oy;
    sample_t           oz;
  } heading_rsp_t;

  // Heading/calibration calculator with its own copy of trackers, offsets
  // and registers; holds the results still due on the response channel.
  class compass_calc;
    sample_t                  trk_max [3];
    sample_t                  trk_min [3];
    sample_t                  offset  [3];
    logic signed [DECL_W-1:0] decl;
    logic [LIMIT_W-1:0]       limit;
    heading_rsp_t             due_results [$];
    int                       mismatches;

    function new();
      for (int k = 0; k < 3; k++) begin
        trk_max[k] = '0;
        trk_min[k] = '0;
        offset[k]  = '0;
      end
      decl       = '0;
      limit      = LIMIT_RESET;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
      if (idx == CFG_DECLINATION) begin
        decl = val;
      end else begin
        limit = val[LIMIT_W-1:0];
      end
    endfunction

    // Vectoring CORDIC, angle in 1/4096 degree, result in [0, 360)
    function int field_angle(int x, int y);
      int tab [16];
      int ang;
      int xs;
      int ys;
      tab = '{184320, 108810, 57492, 29184, 14649, 7331, 3667, 1833,
              917, 458, 229, 115, 57, 29, 14, 7};
      ang = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        x   = -x;
        y   = -y;
        ang = 180 * Q12_DEG;
      end
      for (int i = 0; i < ROT_STEPS && i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x   = x + ys;
          y   = y - xs;
          ang = ang + tab[i];
        end else if (y < 0) begin
          x   = x - ys;
          y   = y + xs;
          ang = ang - tab[i];
        end
      end
      if (ang < 0) ang += 360 * Q12_DEG;
      if (ang >= 360 * Q12_DEG) ang -= 360 * Q12_DEG;
      return ang;
    endfunction

    // Apply one accepted request and queue the result it must produce
    function void note_request(mag_req_t r);
      heading_rsp_t res;
      sample_t      s [3];
      int           a;
      int           h;
      int           v;
      bit           drop;
      s[0] = r.x;
      s[1] = r.y;
      s[2] = r.z;
      res  = '0;
      case (r.kind)
        REQ_HEADING: begin
          a = field_angle(int'(s[0]) - int'(offset[0]), int'(s[1]) - int'(offset[1]))
              - int'(decl) * 256;
          // truncate toward zero, then a true modulo wrap
          h = (a / Q12_DEG + 180) % 360;
          if (h < 0) h += 360;
          res.heading = h[HEAD_W-1:0];
          res.hvalid  = 1'b1;
        end
        REQ_CALIB: begin
          drop = 1'b0;
          for (int k = 0; k < 3; k++) begin
            v = int'(s[k]);
            if ((v < 0 ? -v : v) > int'(limit)) drop = 1'b1;
          end
          if (drop) begin
            res.rejected = 1'b1;
          end else begin
            for (int k = 0; k < 3; k++) begin
              if (s[k] > trk_max[k]) trk_max[k] = s[k];
              if (s[k] < trk_min[k]) trk_min[k] = s[k];
            end
          end
        end
        REQ_COMMIT: begin
          for (int k = 0; k < 3; k++) begin
            offset[k]  = sample_t'((int'(trk_max[k]) + int'(trk_min[k])) / 2);
            trk_max[k] = '0;
            trk_min[k] = '0;
          end
        end
        default: begin
          for (int k = 0; k < 3; k++) offset[k] = s[k];
        end
      endcase
      res.ox = offset[0];
      res.oy = offset[1];
      res.oz = offset[2];
      due_results.push_back(res);
    endfunction

    function void compare_field(string name, int want, int seen);
      if (want != seen) begin
        mismatches++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, seen);
      end
    endfunction

    function void check_result(heading_rsp_t got);
      heading_rsp_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual heading %0d offsets %0d %0d %0d",
                 $time, got.heading, got.ox, got.oy, got.oz);
        return;
      end
      want = due_results.pop_front();
      compare_field("heading_deg", want.heading, got.heading);
      compare_field("heading_valid", want.hvalid, got.hvalid);
      compare_field("sample_rejected", want.rejected, got.rejected);
      compare_field("offset_x", want.ox, got.ox);
      compare_field("offset_y", want.oy, got.oy);
      compare_field("offset_z", want.oz, got.oz);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  int req_idle_pct = 0;
  int rsp_idle_pct = 0;
  int rsp_hold     = 0;
  int stall_cycles = 0;

  compass_calc calc = new();

  cmpcal_req_if req_if ();
  cmpcal_rsp_if rsp_if ();

  compass_hard_iron_calibration_heading i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random back-pressure, or a long hold-off when requested
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold > 0) begin
        rsp_if.ready = 1'b0;
        rsp_hold--;
      end else begin
        rsp_if.ready = ($urandom_range(99) >= rsp_idle_pct);
      end
    end
  end

  // Handshake monitor, scoreboard hookup and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        calc.note_request('{kind: req_type_e'(req_if.req_type), x: req_if.x_value,
                            y: req_if.y_value, z: req_if.z_value});
      end
      if (rsp_if.valid && rsp_if.ready) begin
        calc.check_result('{heading: rsp_if.heading_deg, hvalid: rsp_if.heading_valid,
                            rejected: rsp_if.sample_rejected, ox: rsp_if.offset_x,
                            oy: rsp_if.offset_y, oz: rsp_if.offset_z});
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Offer one request, with random idle cycles ahead of it
  task automatic send_request(req_type_e kind, int x, int y, int z);
    while ($urandom_range(99) < req_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid    = 1'b1;
    req_if.req_type = kind;
    req_if.x_value  = sample_t'(x);
    req_if.y_value  = sample_t'(y);
    req_if.z_value  = sample_t'(z);
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain();
    req_if.valid = 1'b0;
    while (calc.due_results.size() != 0) @(negedge clk);
  endtask

  task automatic configure(int decl, int limit);
    drain();
    cfg_we    = 1'b1;
    cfg_idx   = CFG_DECLINATION;
    cfg_wdata = CFG_W'(decl);
    calc.set_reg(CFG_DECLINATION, CFG_W'(decl));
    @(negedge clk);
    cfg_idx   = CFG_REJECT_LIMIT;
    cfg_wdata = CFG_W'(limit);
    calc.set_reg(CFG_REJECT_LIMIT, CFG_W'(limit));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic int any_sample();
    return int'($urandom_range(8191)) - 4096;
  endfunction

  // Mostly within the reject limit, sometimes anywhere
  function automatic int cal_sample();
    int lim;
    lim = int'(calc.limit);
    if ($urandom_range(9) == 0) return any_sample();
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  // Calibration sessions, offset loads with headings, and loose noise
  task automatic run_traffic(int n);
    int done;
    int pick;
    int k;
    int m;
    int lx;
    int ly;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        k = $urandom_range(3, 10);
        m = $urandom_range(1, 4);
        repeat (k) send_request(REQ_CALIB, cal_sample(), cal_sample(), cal_sample());
        send_request(REQ_COMMIT, any_sample(), any_sample(), any_sample());
        repeat (m) send_request(REQ_HEADING, any_sample(), any_sample(), any_sample());
        done += k + 1 + m;
      end else if (pick < 70) begin
        lx = any_sample();
        ly = any_sample();
        m  = $urandom_range(1, 4);
        send_request(REQ_LOAD, lx, ly, any_sample());
        repeat (m) begin
          // sample equal to the offset gives a zero vector
          if ($urandom_range(3) == 0) begin
            send_request(REQ_HEADING, lx, ly, any_sample());
          end else begin
            send_request(REQ_HEADING, any_sample(), any_sample(), any_sample());
          end
        end
        done += 1 + m;
      end else begin
        send_request(req_type_e'($urandom_range(3)), any_sample(), any_sample(),
                     any_sample());
        done++;
      end
    end
  endtask

  initial begin
    int decl_plan  [9];
    int limit_plan [9];
    int decl;
    int limit;
    decl_plan  = '{2880, -2880, PICK_RANDOM, 0, PICK_RANDOM, -2880,
                   PICK_RANDOM, PICK_RANDOM, 2880};
    limit_plan = '{4095, 0, 1000, 4095, PICK_RANDOM, PICK_RANDOM,
                   PICK_RANDOM, PICK_RANDOM, 0};
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_DECLINATION;
    cfg_wdata      = '0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_HEADING;
    req_if.x_value  = '0;
    req_if.y_value  = '0;
    req_if.z_value  = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed: axis extremes, zero vector, reject edges, commit rounding
    send_request(REQ_HEADING, 0, 0, 0);
    send_request(REQ_HEADING, 4095, 0, -4096);
    send_request(REQ_HEADING, -4096, 0, 4095);
    send_request(REQ_HEADING, 0, 4095, 0);
    send_request(REQ_HEADING, 0, -4096, 0);
    send_request(REQ_HEADING, -4096, -4096, 0);
    send_request(REQ_HEADING, 4095, 4095, 0);
    send_request(REQ_CALIB, -4096, 0, 0);
    send_request(REQ_CALIB, 1000, -1000, 0);
    send_request(REQ_CALIB, 1001, 0, 0);
    send_request(REQ_CALIB, -3, 5, 1000);
    send_request(REQ_CALIB, 0, 0, -1000);
    send_request(REQ_COMMIT, 0, 0, 0);
    send_request(REQ_HEADING, 498, -497, 0);
    send_request(REQ_COMMIT, 0, 0, 0);
    send_request(REQ_LOAD, 4095, -4096, -1);
    send_request(REQ_HEADING, -4096, 4095, 0);
    send_request(REQ_HEADING, 4095, -4096, 0);
    send_request(REQ_LOAD, 0, 0, 0);
    // positive declination drives the angle negative before the degree conversion
    configure(2880, 4095);
    send_request(REQ_HEADING, 1, 1, 0);
    send_request(REQ_CALIB, -4096, 4095, 4095);
    send_request(REQ_CALIB, 4095, -4095, 4095);
    configure(-2880, 0);
    send_request(REQ_HEADING, -1, -1, 0);
    send_request(REQ_CALIB, 0, 0, 0);
    send_request(REQ_CALIB, 1, 0, 0);

    // Random traffic in three idle profiles, new register values per chunk
    for (int c = 0; c < 9; c++) begin
      decl  = (decl_plan[c] == PICK_RANDOM) ? int'($urandom_range(5760)) - 2880
                                            : decl_plan[c];
      limit = (limit_plan[c] == PICK_RANDOM) ? int'($urandom_range(4095)) : limit_plan[c];
      configure(decl, limit);
      if (c < 3) begin
        req_idle_pct = 27;
        rsp_idle_pct = 66;
      end else if (c < 6) begin
        req_idle_pct = 66;
        rsp_idle_pct = 27;
      end else begin
        req_idle_pct = 0;
        rsp_idle_pct = 0;
      end
      // long result hold-off so the input backs up
      if (c == 6) rsp_hold = 300;
      run_traffic(CHUNK_LEN);
    end

    drain();
    repeat (40) @(negedge clk);
    if (calc.mismatches == 0 && calc.due_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
